// ===== hdl/vm_register_instruction_execute_macros.svh =====
// Assertion macros used by the checker file
`ifndef VM_REGISTER_INSTRUCTION_EXECUTE_MACROS_SVH
`define VM_REGISTER_INSTRUCTION_EXECUTE_MACROS_SVH

// Check a property at every rising edge outside reset
`define VMX_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vmx: property violated");

// Check that a stalled channel keeps its valid and payload
`define VMX_ASSERT_HOLD(label, clk, rst, vld, stl, sig) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && stl) |=> (vld && $stable(sig))) \
      else $error("vmx: stalled item changed");

`endif

// ===== hdl/vmx_pkg.sv =====
package vmx_pkg;

   localparam int DATA_W    = 32;
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] IMM_MASK = 32'h01ff_ffff;
   localparam logic [DATA_W-1:0] CHAR_MAX = 32'h0000_00ff;

   // Opcodes
   localparam logic [3:0] OP_CMOV      = 4'd0;
   localparam logic [3:0] OP_ARR_INDEX = 4'd1;
   localparam logic [3:0] OP_ARR_AMEND = 4'd2;
   localparam logic [3:0] OP_ADD       = 4'd3;
   localparam logic [3:0] OP_MUL       = 4'd4;
   localparam logic [3:0] OP_DIV       = 4'd5;
   localparam logic [3:0] OP_NAND      = 4'd6;
   localparam logic [3:0] OP_HALT      = 4'd7;
   localparam logic [3:0] OP_ALLOC     = 4'd8;
   localparam logic [3:0] OP_FREE      = 4'd9;
   localparam logic [3:0] OP_OUTPUT    = 4'd10;
   localparam logic [3:0] OP_INPUT     = 4'd11;
   localparam logic [3:0] OP_LOAD_PROG = 4'd12;
   localparam logic [3:0] OP_LOAD_IMM  = 4'd13;

   // Result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HALT     = 3'd1;
   localparam logic [2:0] ST_DIV0     = 3'd2;
   localparam logic [2:0] ST_BADCHAR  = 3'd3;
   localparam logic [2:0] ST_INVALID  = 3'd4;
   localparam logic [2:0] ST_ARRAY    = 3'd5;
   localparam logic [2:0] ST_STOPPED  = 3'd6;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [8:0]  in_char;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_valid;
      logic [7:0]  out_char;
      logic [31:0] b_value;
      logic [31:0] c_value;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic read;
      logic decode;
      logic mul;
      logic div_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } sts_type;

endpackage

// ===== hdl/vmx_ctrl.sv =====
module vmx_ctrl
   import vmx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DECODE,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result slot can take a new item when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item through read, execute and write-back
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            priority if (sts.is_mul) state_in = S_MUL;
            else if (sts.is_div)     state_in = S_DIV;
            else                     state_in = S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/vmx_dpath.sv =====
module vmx_dpath
   import vmx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   output rsp_type rsp_data,
   input  cmd_type cmd,
   output sts_type sts
);

   // Register file storage and its written marks
   logic [DATA_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;

   req_type              instr_ff;
   logic [DATA_W-1:0]    b_data_ff, c_data_ff;
   logic                 b_vld_ff, c_vld_ff;
   logic                 stopped_ff;

   // Pending result of the current item
   logic [2:0]           pend_status_ff, pend_status_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [7:0]           pend_char_ff, pend_char_in;
   logic [DATA_W-1:0]    pend_b_ff, pend_b_in;
   logic [DATA_W-1:0]    pend_c_ff, pend_c_in;
   logic                 pend_we_ff, pend_we_in;
   logic [REG_IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0]    pend_val_ff, pend_val_in;
   logic                 pend_stop_ff, pend_stop_in;

   // Divider state
   logic [DATA_W-1:0]    rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DATA_W:0]      rem_sh, trial;
   logic                 q_bit;

   logic [DATA_W-1:0]    vb, vc;
   logic [2*DATA_W-1:0]  prod;
   logic [3:0]           op;
   logic [REG_IDX_W-1:0] ra, rb, rc, rimm;
   rsp_type              rsp_ff;

   assign op   = instr_ff.instr_word[31:28];
   assign ra   = instr_ff.instr_word[8:6];
   assign rb   = instr_ff.instr_word[5:3];
   assign rc   = instr_ff.instr_word[2:0];
   assign rimm = instr_ff.instr_word[27:25];

   // Never-written registers read as zero
   assign vb = b_vld_ff ? b_data_ff : '0;
   assign vc = c_vld_ff ? c_data_ff : '0;

   assign prod = vb * vc;

   // One restoring division step
   assign rem_sh = {rem_ff, pend_val_ff[DATA_W-1]};
   assign trial  = rem_sh - {1'b0, vc};
   assign q_bit  = !trial[DATA_W];

   assign sts.is_mul   = !stopped_ff && (op == OP_MUL);
   assign sts.is_div   = !stopped_ff && (op == OP_DIV) && (vc != '0);
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Decode the item into its pending result
   always_comb begin
      pend_status_in = ST_OK;
      pend_valid_in  = 1'b0;
      pend_char_in   = '0;
      pend_b_in      = '0;
      pend_c_in      = '0;
      pend_we_in     = 1'b0;
      pend_addr_in   = ra;
      pend_val_in    = '0;
      pend_stop_in   = 1'b0;
      if (stopped_ff) begin
         pend_status_in = ST_STOPPED;
      end else begin
         unique case (op)
            OP_CMOV: begin
               pend_we_in  = (vc != '0);
               pend_val_in = vb;
            end
            OP_ADD: begin
               pend_we_in  = 1'b1;
               pend_val_in = vb + vc;
            end
            OP_MUL: begin
               pend_we_in = 1'b1;
            end
            OP_DIV: begin
               if (vc == '0) begin
                  pend_status_in = ST_DIV0;
                  pend_stop_in   = 1'b1;
               end else begin
                  pend_we_in  = 1'b1;
                  pend_val_in = vb;
               end
            end
            OP_NAND: begin
               pend_we_in  = 1'b1;
               pend_val_in = ~(vb & vc);
            end
            OP_HALT: begin
               pend_status_in = ST_HALT;
               pend_stop_in   = 1'b1;
            end
            OP_OUTPUT: begin
               if (vc > CHAR_MAX) begin
                  pend_status_in = ST_BADCHAR;
                  pend_stop_in   = 1'b1;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_char_in  = vc[7:0];
               end
            end
            OP_INPUT: begin
               pend_we_in   = 1'b1;
               pend_addr_in = rc;
               // End of input and anything above a byte load all ones
               pend_val_in  = instr_ff.in_char[8] ? '1 : DATA_W'(instr_ff.in_char);
            end
            OP_LOAD_IMM: begin
               pend_we_in   = 1'b1;
               pend_addr_in = rimm;
               pend_val_in  = instr_ff.instr_word & IMM_MASK;
            end
            OP_ARR_INDEX, OP_ARR_AMEND, OP_ALLOC, OP_FREE, OP_LOAD_PROG: begin
               pend_status_in = ST_ARRAY;
               pend_b_in      = vb;
               pend_c_in      = vc;
            end
            default: begin
               pend_status_in = ST_INVALID;
               pend_stop_in   = 1'b1;
            end
         endcase
      end
   end

   // Register file: registered reads, write-back at finish
   always_ff @(posedge clock) begin
      if (cmd.finish && pend_we_ff) mem[pend_addr_ff] <= pend_val_ff;
      if (cmd.read) begin
         b_data_ff <= mem[rb];
         c_data_ff <= mem[rc];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) instr_ff <= req_data;
      if (cmd.decode) begin
         pend_status_ff <= pend_status_in;
         pend_valid_ff  <= pend_valid_in;
         pend_char_ff   <= pend_char_in;
         pend_b_ff      <= pend_b_in;
         pend_c_ff      <= pend_c_in;
         pend_we_ff     <= pend_we_in;
         pend_addr_ff   <= pend_addr_in;
         pend_val_ff    <= pend_val_in;
         rem_ff         <= '0;
         cnt_ff         <= '0;
      end
      if (cmd.mul) pend_val_ff <= prod[DATA_W-1:0];
      // Shift the quotient into the dividend register
      if (cmd.div_step) begin
         rem_ff      <= q_bit ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         pend_val_ff <= {pend_val_ff[DATA_W-2:0], q_bit};
         cnt_ff      <= cnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_ff.status    <= pend_status_ff;
         rsp_ff.out_valid <= pend_valid_ff;
         rsp_ff.out_char  <= pend_char_ff;
         rsp_ff.b_value   <= pend_b_ff;
         rsp_ff.c_value   <= pend_c_ff;
      end
   end

   // Control state: written marks, read marks, stop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff    <= '0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         pend_stop_ff <= 1'b0;
      end else begin
         if (cmd.read) begin
            b_vld_ff <= rf_vld_ff[rb];
            c_vld_ff <= rf_vld_ff[rc];
         end
         if (cmd.decode) pend_stop_ff <= pend_stop_in;
         if (cmd.finish) begin
            if (pend_we_ff) rf_vld_ff[pend_addr_ff] <= 1'b1;
            if (pend_stop_ff) stopped_ff <= 1'b1;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/vm_register_instruction_execute.sv =====
// Executes one 32-bit instruction word per item against eight 32-bit
// registers and returns one result item per item. Items are taken one at
// a time, each through idle, read, decode and done, with a multiply or
// divide state before done; a single restoring divider retires one
// quotient bit per cycle. Done waits while the previous result is held
// in the output register under rsp_stall. Register reads are registered,
// so each item has a read state before it executes. Halt, divide by zero,
// a bad output character and opcodes 14 and 15 stop the block; every
// later item then returns status stopped and changes nothing until reset.
module vm_register_instruction_execute
   import vmx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   vmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vmx_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

// ===== hdl/vmx_checker.sv =====
`include "vm_register_instruction_execute_macros.svh"

module vmx_checker
   import vmx_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_take, rsp_take, stop_seen;
   logic is_stopped, is_array, bc_zero;
   logic seen_stop_ff;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign stop_seen = rsp_take && ((rsp_data.status == ST_HALT) ||
                      (rsp_data.status == ST_DIV0) || (rsp_data.status == ST_BADCHAR) ||
                      (rsp_data.status == ST_INVALID));

   // Classify the result on the port
   assign is_stopped = (rsp_data.status == ST_STOPPED);
   assign is_array   = (rsp_data.status == ST_ARRAY);
   assign bc_zero    = (rsp_data.b_value == '0) && (rsp_data.c_value == '0);

   // Remember that a stopping result went out
   always_ff @(posedge clock) begin
      if (reset) seen_stop_ff <= 1'b0;
      else if (stop_seen) seen_stop_ff <= 1'b1;
   end

   `VMX_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_stall, rsp_data)
   `VMX_ASSERT(a_busy_after_take, clock, reset, req_take |=> req_stall)
   `VMX_ASSERT(a_stays_stopped, clock, reset, (rsp_valid && seen_stop_ff) |-> is_stopped)
   `VMX_ASSERT(a_char_only_ok, clock, reset, (rsp_valid && rsp_data.out_valid) |-> (rsp_data.status == ST_OK))
   `VMX_ASSERT(a_bc_only_array, clock, reset, (rsp_valid && !is_array) |-> bc_zero)

endmodule

bind vm_register_instruction_execute vmx_checker u_checker (.*);

// ===== bench/tb_vm_register_instruction_execute.sv =====
module tb_vm_register_instruction_execute;
   import vmx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes outside the package that must stop the machine
   localparam logic [3:0] OP_BAD_14 = 4'd14;
   localparam logic [3:0] OP_BAD_15 = 4'd15;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 64;
   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_ITEMS  = 200;

   typedef enum {
      STOP_HALT, STOP_DIV0, STOP_BADCHAR, STOP_OP14, STOP_OP15
   } stop_kind_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Machine state as the bench sees it
   logic [31:0] vm_regs [8];
   logic        vm_stopped;

   rsp_type predicted_rsp [$];
   int          fail_count  = 0;
   int          cycle_count = 0;
   int          stall_left  = 0;
   logic        gaps_on     = 1'b0;
   logic        stalls_on   = 1'b0;

   // Opcodes that keep the machine running
   logic [3:0] run_ops [13] = '{OP_CMOV, OP_ARR_INDEX, OP_ARR_AMEND, OP_ADD, OP_MUL,
                                OP_DIV, OP_NAND, OP_ALLOC, OP_FREE, OP_OUTPUT,
                                OP_INPUT, OP_LOAD_PROG, OP_LOAD_IMM};

   vm_register_instruction_execute uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Execute one instruction on the bench copy of the machine
   function automatic rsp_type run_instruction(req_type item);
      rsp_type     res;
      logic [3:0]  op;
      logic [31:0] vb;
      logic [31:0] vc;
      logic [2:0]  ra;
      logic [2:0]  rc;
      res = '0;
      op  = item.instr_word[31:28];
      ra  = item.instr_word[8:6];
      rc  = item.instr_word[2:0];
      vb  = vm_regs[item.instr_word[5:3]];
      vc  = vm_regs[rc];
      if (vm_stopped) begin
         res.status = ST_STOPPED;
      end else begin
         res.status = ST_OK;
         case (op)
            OP_CMOV: begin
               if (vc != 0) vm_regs[ra] = vb;
            end
            OP_ADD:  vm_regs[ra] = vb + vc;
            OP_MUL:  vm_regs[ra] = vb * vc;
            OP_DIV: begin
               if (vc == 0) begin
                  res.status = ST_DIV0;
                  vm_stopped = 1'b1;
               end else begin
                  vm_regs[ra] = vb / vc;
               end
            end
            OP_NAND: vm_regs[ra] = ~(vb & vc);
            OP_HALT: begin
               res.status = ST_HALT;
               vm_stopped = 1'b1;
            end
            OP_OUTPUT: begin
               if (vc > CHAR_MAX) begin
                  res.status = ST_BADCHAR;
                  vm_stopped = 1'b1;
               end else begin
                  res.out_valid = 1'b1;
                  res.out_char  = vc[7:0];
               end
            end
            OP_INPUT: begin
               vm_regs[rc] = (item.in_char > 9'd255) ? 32'hffff_ffff
                                                     : {23'd0, item.in_char};
            end
            OP_LOAD_IMM: vm_regs[item.instr_word[27:25]] = item.instr_word & IMM_MASK;
            OP_ARR_INDEX, OP_ARR_AMEND, OP_ALLOC, OP_FREE, OP_LOAD_PROG: begin
               res.status  = ST_ARRAY;
               res.b_value = vb;
               res.c_value = vc;
            end
            default: begin
               res.status = ST_INVALID;
               vm_stopped = 1'b1;
            end
         endcase
      end
      return res;
   endfunction

   function automatic logic [31:0] abc_instr(logic [3:0] op, int a, int b, int c);
      return {op, 19'd0, a[2:0], b[2:0], c[2:0]};
   endfunction

   function automatic logic [31:0] imm_instr(int r, logic [24:0] value);
      return {OP_LOAD_IMM, r[2:0], value};
   endfunction

   function automatic logic [8:0] random_char();
      case ($urandom_range(0, 3))
         0:       return 9'd256;
         1:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(0, 255));
      endcase
   endfunction

   // Build a random instruction that keeps the machine running
   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [3:0]  op;
      logic        found;
      int          pick;
      int          k;
      int          idx;
      w = $urandom;
      // small loads feed output and divide with usable operands
      if ($urandom_range(0, 4) == 0) return {OP_LOAD_IMM, w[27:25], 17'd0, w[7:0]};
      op = run_ops[$urandom_range(0, 12)];
      w[31:28] = op;
      if (op == OP_DIV || op == OP_OUTPUT) begin
         found = 1'b0;
         pick  = $urandom_range(0, 7);
         for (k = 0; k < 8; k++) begin
            idx = (pick + k) % 8;
            if (!found && ((op == OP_DIV) ? (vm_regs[idx] != 0)
                                         : (vm_regs[idx] <= CHAR_MAX))) begin
               w[2:0] = idx[2:0];
               found  = 1'b1;
            end
         end
         if (!found) w = {OP_LOAD_IMM, w[27:25], 17'd0, w[7:0]};
      end
      return w;
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic send_instr(input logic [31:0] word, input logic [8:0] ch);
      logic taken;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{instr_word: word, in_char: ch};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (req_stall === 1'b0) begin
            taken = 1'b1;
            predicted_rsp.push_back(run_instruction(req_data));
         end
         @(posedge clock);
      end
   endtask

   // Drop valid and wait for every awaited result
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_rsp.size() != 0);
   endtask

   task automatic test_directed_ops();
      // reset contents seen through an array op
      send_instr(abc_instr(OP_ARR_INDEX, 0, 7, 0), 9'd0);
      send_instr(imm_instr(7, 25'h1ff_ffff), 9'd511);
      send_instr(imm_instr(0, 25'd0), 9'd0);
      send_instr(abc_instr(OP_NAND, 1, 0, 0), random_char());
      send_instr(abc_instr(OP_ADD, 2, 1, 1), random_char());
      send_instr(abc_instr(OP_MUL, 3, 1, 1), random_char());
      send_instr(abc_instr(OP_MUL, 4, 7, 7), random_char());
      send_instr(abc_instr(OP_DIV, 5, 1, 7), random_char());
      send_instr(abc_instr(OP_DIV, 6, 7, 1), random_char());
      // conditional move with zero and nonzero condition
      send_instr(abc_instr(OP_CMOV, 0, 1, 0), random_char());
      send_instr(abc_instr(OP_CMOV, 0, 7, 3), random_char());
      // input extremes, end of input and out-of-range codes
      send_instr(abc_instr(OP_INPUT, 7, 7, 4), 9'd0);
      send_instr(abc_instr(OP_INPUT, 0, 0, 5), 9'd255);
      send_instr(abc_instr(OP_INPUT, 0, 0, 6), 9'd256);
      send_instr(abc_instr(OP_INPUT, 0, 0, 3), 9'd511);
      send_instr(abc_instr(OP_OUTPUT, 0, 0, 4), random_char());
      send_instr(abc_instr(OP_OUTPUT, 7, 7, 5), random_char());
      // array ops pass B and C through
      send_instr(abc_instr(OP_ARR_AMEND, 2, 1, 7), random_char());
      send_instr(abc_instr(OP_ALLOC, 0, 6, 2), random_char());
      send_instr(abc_instr(OP_FREE, 0, 0, 4), random_char());
      send_instr(abc_instr(OP_LOAD_PROG, 3, 7, 1), random_char());
      send_instr({OP_ARR_INDEX, 28'hfff_ffff}, 9'd511);
   endtask

   task automatic test_random_program(input int count);
      repeat (count) send_instr(random_instr(), random_char());
   endtask

   // Stop the machine one way, then check that later items change nothing
   task automatic test_stop_and_after();
      stop_kind_type kind;
      kind = stop_kind_type'($urandom_range(0, 4));
      case (kind)
         STOP_HALT:    send_instr({OP_HALT, 28'($urandom)}, random_char());
         STOP_DIV0: begin
            send_instr(imm_instr(2, 25'd0), random_char());
            send_instr(abc_instr(OP_DIV, 1, 3, 2), random_char());
         end
         STOP_BADCHAR: begin
            send_instr(imm_instr(2, 25'($urandom_range(256, 32'h1ff_ffff))), random_char());
            send_instr(abc_instr(OP_OUTPUT, 0, 0, 2), random_char());
         end
         STOP_OP14:    send_instr({OP_BAD_14, 28'($urandom)}, random_char());
         default:      send_instr({OP_BAD_15, 28'($urandom)}, random_char());
      endcase
      repeat (16) send_instr($urandom, random_char());
      send_instr(abc_instr(OP_HALT, 0, 0, 0), random_char());
      send_instr({OP_BAD_15, 28'd0}, random_char());
   endtask

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (!stalls_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(negedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_rsp.size() == 0) begin
            $error("result item with none awaited: %h", rsp_data);
            fail_count++;
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.out_valid !== want.out_valid) begin
               $error("out_valid expected %0d got %0d", want.out_valid, rsp_data.out_valid);
               fail_count++;
            end
            if (rsp_data.out_char !== want.out_char) begin
               $error("out_char expected %h got %h", want.out_char, rsp_data.out_char);
               fail_count++;
            end
            if (rsp_data.b_value !== want.b_value) begin
               $error("b_value expected %h got %h", want.b_value, rsp_data.b_value);
               fail_count++;
            end
            if (rsp_data.c_value !== want.c_value) begin
               $error("c_value expected %h got %h", want.c_value, rsp_data.c_value);
               fail_count++;
            end
         end
      end
   end

   // End a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      for (int i = 0; i < 8; i++) vm_regs[i] = '0;
      vm_stopped = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_directed_ops();
      wait_all_results();
      test_random_program(RANDOM_ITEMS);
      wait_all_results();

      // tail of the run without any idling
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_random_program(QUIET_ITEMS);
      test_stop_and_after();
      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (predicted_rsp.size() != 0) begin
         $error("%0d result items never arrived", predicted_rsp.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vmx_pkg.sv
hdl/vmx_ctrl.sv
hdl/vmx_dpath.sv
hdl/vm_register_instruction_execute.sv
hdl/vmx_checker.sv
bench/tb_vm_register_instruction_execute.sv
